// ===== rtl/stq_pkg.sv =====
package stq_pkg;

    localparam int unsigned MaxElements = 1024;
    localparam int unsigned Levels      = 11;
    localparam int unsigned ValW        = 64;
    localparam int unsigned ModeW       = 3;
    localparam int unsigned IdxW        = 10;

    // operator codes
    localparam logic [ModeW-1:0] OP_MIN = 3'd0;
    localparam logic [ModeW-1:0] OP_MAX = 3'd1;
    localparam logic [ModeW-1:0] OP_GCD = 3'd2;
    localparam logic [ModeW-1:0] OP_AND = 3'd3;
    localparam logic [ModeW-1:0] OP_OR  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NOBLD = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // handshake between the sequencer and the combine unit
    typedef struct packed {
        logic            start;
        logic [ModeW-1:0] mode;
    } t_cmb_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cmb_rsp;

endpackage

// ===== rtl/sparse_table_range_query.sv =====
// a load is answered through S_OUT; a query runs S_Q_RDA, S_Q_RDB, S_CMB, S_WAIT and S_OUT
// (min/max/and/or), and with gcd S_WAIT lasts longer while the combine unit iterates
// throughput: one item at a time; set by the single memory port and the combine unit
// a build on load_last runs S_B_RDA, S_B_RDB, S_B_CMB, S_B_WAIT per table entry written (longer with gcd)
// reset: synchronous active low; count, built flag and mode clear, table memory is not
// cleared and entries are valid only once written
module sparse_table_range_query
    import stq_pkg::*;
#(
    parameter int unsigned MAX_ELEMENTS = MaxElements,
    parameter int unsigned LEVELS       = Levels
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // load_value[63:0], range_left[73:64], range_right[83:74]
    input  logic        s_axis_tuser,  // req_type
    input  logic        s_axis_tlast,  // load_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // answer
    output logic [1:0]  m_axis_tuser,  // status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data     // op_mode
);

    localparam int unsigned CntW = $clog2(MAX_ELEMENTS + 1);
    localparam int unsigned AW   = $clog2(MAX_ELEMENTS);
    localparam int unsigned LW   = $clog2(LEVELS);
    localparam int unsigned Depth = LEVELS * MAX_ELEMENTS;
    localparam int unsigned MW   = $clog2(Depth);

    typedef enum logic [3:0] {
        S_IDLE, S_Q_RDA, S_Q_RDB, S_CMB, S_WAIT, S_OUT,
        S_B_RDA, S_B_RDB, S_B_CMB, S_B_WAIT
    } t_state;

    // table memory, one port per cycle
    logic [ValW-1:0] r_mem [Depth];
    logic [ValW-1:0] r_rd;
    logic            mem_we;
    logic [MW-1:0]   mem_addr;
    logic [ValW-1:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wd;
        r_rd <= r_mem[mem_addr];
    end

    t_state           r_state;
    logic [CntW-1:0]  r_count;
    logic             r_built;
    logic [ModeW-1:0] r_mode, r_bmode;
    logic [ValW-1:0]  r_a, r_ans;
    logic [1:0]       r_status;
    logic             r_ovalid;
    logic [LW-1:0]    r_lvl;
    logic [AW-1:0]    r_i, r_j;

    t_cmb_req cmb_req;
    t_cmb_rsp cmb_rsp;
    logic [ValW-1:0] cmb_res;

    stq_combine u_cmb (
        .i_clk, .i_rst_n, .i_req(cmb_req), .i_a(r_a), .i_b(r_rd),
        .o_rsp(cmb_rsp), .o_res(cmb_res)
    );

    wire             req_q = s_axis_tuser;
    wire [ValW-1:0]  ld_v  = s_axis_tdata[63:0];
    wire [IdxW-1:0]  ql    = s_axis_tdata[73:64];
    wire [IdxW-1:0]  qr    = s_axis_tdata[83:74];
    wire             in_ok = s_axis_tvalid && s_axis_tready;

    // floor log2 of the query length
    logic [IdxW:0]  qlen;
    logic [LW-1:0]  qlvl;
    always_comb begin
        qlen = {1'b0, qr} - {1'b0, ql} + 1'b1;
        qlvl = '0;
        for (int k = 1; k < LEVELS && k <= IdxW; k++)
            if (qlen >= (IdxW+1)'(1 << k)) qlvl = LW'(k);
    end

    // build loop bounds
    logic [CntW:0] lvl_size, next_size;
    assign lvl_size  = (CntW+1)'(1) << r_lvl;
    assign next_size = lvl_size << 1;

    wire [CntW-1:0] cnt_eff = r_built ? '0 : r_count;

    function automatic logic [MW-1:0] addr_of(input logic [LW-1:0] lv, input logic [AW-1:0] ix);
        addr_of = MW'(lv * MAX_ELEMENTS) + MW'(ix);
    endfunction

    // memory port mux
    always_comb begin
        mem_we   = 1'b0;
        mem_addr = addr_of(r_lvl, r_i);
        mem_wd   = ld_v;
        cmb_req.start = 1'b0;
        cmb_req.mode  = r_bmode;
        unique case (r_state)
            S_IDLE: begin
                mem_addr = MW'(cnt_eff[AW-1:0]);
                mem_we   = in_ok && !req_q && (cnt_eff < CntW'(MAX_ELEMENTS));
            end
            S_Q_RDA, S_B_RDA: mem_addr = addr_of(r_lvl, r_i);
            S_Q_RDB, S_B_RDB: mem_addr = addr_of(r_lvl, r_j);
            S_CMB, S_B_CMB:   cmb_req.start = 1'b1;
            S_B_WAIT: begin
                mem_addr = addr_of(r_lvl + 1'b1, r_i);
                mem_wd   = cmb_res;
                mem_we   = cmb_rsp.done;
            end
            default: ;
        endcase
    end

    wire [CntW-1:0] cnt_new = cnt_eff + ((cnt_eff < CntW'(MAX_ELEMENTS)) ? 1'b1 : 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_built  <= 1'b0;
            r_mode   <= '0;
            r_bmode  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_mode <= i_cfg_data;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (in_ok) begin
                    r_ans <= '0;
                    if (!req_q) begin
                        r_count  <= cnt_new;
                        r_built  <= 1'b0;
                        r_status <= (cnt_eff < CntW'(MAX_ELEMENTS)) ? ST_OK : ST_FULL;
                        if (s_axis_tlast) begin
                            r_bmode <= r_mode;
                            r_lvl   <= '0;
                            r_i     <= '0;
                            r_state <= S_B_RDA;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else if (!r_built) begin
                        r_status <= ST_NOBLD;
                        r_state  <= S_OUT;
                    end else if (ql > qr || CntW'(qr) >= r_count) begin
                        r_status <= ST_RANGE;
                        r_state  <= S_OUT;
                    end else begin
                        r_status <= ST_OK;
                        r_lvl    <= qlvl;
                        r_i      <= AW'(ql);
                        r_j      <= AW'(qr + 1'b1 - (IdxW'(1) << qlvl));
                        r_state  <= S_Q_RDA;
                    end
                end
                S_Q_RDA: r_state <= S_Q_RDB;
                S_Q_RDB: begin r_a <= r_rd; r_state <= S_CMB; end
                S_CMB:   r_state <= S_WAIT;
                S_WAIT: if (cmb_rsp.done) begin
                    r_ans   <= cmb_res;
                    r_state <= S_OUT;
                end
                S_OUT: if (!r_ovalid) begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                // build: level lvl+1 from level lvl while next size fits the count
                S_B_RDA: begin
                    if (r_lvl >= LW'(LEVELS - 1) || next_size > (CntW+1)'(r_count)) begin
                        r_built <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_j     <= AW'(r_i + lvl_size);
                        r_state <= S_B_RDB;
                    end
                end
                S_B_RDB: begin r_a <= r_rd; r_state <= S_B_CMB; end
                S_B_CMB: r_state <= S_B_WAIT;
                S_B_WAIT: if (cmb_rsp.done) begin
                    if ((CntW+1)'(r_i) + lvl_size + 1'b1 < (CntW+1)'(r_count)) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_i   <= '0;
                        r_lvl <= r_lvl + 1'b1;
                    end
                    r_state <= S_B_RDA;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // read issued in RDB is for B; RDA data arrives in RDB
    // (S_Q_RDB latches A, S_CMB sees B on r_rd)

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_ans;
    assign m_axis_tuser  = r_status;

`ifndef NO_ASSERTIONS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MAX_ELEMENTS)) else $error("count overflow");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ok |=> !s_axis_tready) else $error("accepted while busy");
    a_cmb_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmb_req.start |-> !cmb_rsp.busy) else $error("combine overlap");
`endif

endmodule

// ===== rtl/stq_combine.sv =====
// combine unit: min/max/and/or registered straight from the start, gcd by binary steps
module stq_combine
    import stq_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmb_req        i_req,
    input  logic [ValW-1:0] i_a,
    input  logic [ValW-1:0] i_b,
    output t_cmb_rsp        o_rsp,
    output logic [ValW-1:0] o_res
);

    typedef enum logic [1:0] {S_IDLE, S_GCD, S_FIN} t_state;

    t_state                r_state;
    logic [ValW-1:0]       r_u, r_v, r_res;
    logic [$clog2(ValW+1)-1:0] r_sh;
    logic                  r_done;

    logic [ValW-1:0] ma, mb, simple;
    logic            a_less;

    assign ma     = i_a[ValW-1] ? (~i_a + 1'b1) : i_a;
    assign mb     = i_b[ValW-1] ? (~i_b + 1'b1) : i_b;
    assign a_less = $signed(i_a) < $signed(i_b);

    // non-iterative operators
    always_comb begin
        unique case (i_req.mode)
            OP_MAX:  simple = a_less ? i_b : i_a;
            OP_AND:  simple = i_a & i_b;
            OP_OR:   simple = i_a | i_b;
            default: simple = a_less ? i_a : i_b;
        endcase
    end

    // binary gcd step values
    logic [ValW-1:0] diff, big, small_v;
    assign big     = (r_u > r_v) ? r_u : r_v;
    assign small_v = (r_u > r_v) ? r_v : r_u;
    assign diff    = big - small_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        if (i_req.mode == OP_GCD) begin
                            r_u     <= ma;
                            r_v     <= mb;
                            r_sh    <= '0;
                            r_state <= S_GCD;
                        end else begin
                            r_res  <= simple;
                            r_done <= 1'b1;
                        end
                    end
                end
                S_GCD: begin
                    if (r_u == '0) begin
                        r_res   <= r_v;
                        r_state <= S_FIN;
                    end else if (r_v == '0) begin
                        r_res   <= r_u;
                        r_state <= S_FIN;
                    end else if (!r_u[0] && !r_v[0]) begin
                        r_u  <= r_u >> 1;
                        r_v  <= r_v >> 1;
                        r_sh <= r_sh + 1'b1;
                    end else if (!r_u[0]) begin
                        r_u <= r_u >> 1;
                    end else if (!r_v[0]) begin
                        r_v <= r_v >> 1;
                    end else begin
                        r_u <= small_v;
                        r_v <= diff;
                    end
                end
                S_FIN: begin
                    r_res   <= r_res << r_sh;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.busy = (r_state != S_IDLE);
    assign o_rsp.done = r_done;
    assign o_res      = r_res;

`ifndef NO_ASSERTIONS
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.busy |-> !i_req.start) else $error("combine started while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |-> !o_rsp.busy) else $error("done while busy");
    a_fin_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN |=> o_rsp.done) else $error("gcd finish lost");
`endif

endmodule

// ===== tb/stq_checker.sv =====
`timescale 1ns / 100ps

module stq_checker
    import stq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [87:0] i_s_tdata,   // load_value[63:0], range_left[73:64], range_right[83:74]
    input  logic        i_s_tuser,   // req_type
    input  logic        i_s_tlast,   // load_last
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,   // answer
    input  logic [1:0]  i_m_tuser,   // status
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);

    typedef struct packed {
        logic [63:0] answer;
        logic [1:0]  status;
    } t_answer;

    // shadow copy of the table and its bookkeeping
    logic [63:0]      level_mem [Levels][MaxElements];
    int unsigned      elem_count;
    bit               is_built;
    logic [ModeW-1:0] mode_reg;
    logic [ModeW-1:0] table_mode;
    t_answer          answer_q[$];

    function automatic logic [63:0] magnitude(logic [63:0] a);
        return a[63] ? (~a + 64'd1) : a;
    endfunction

    function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // idempotent operator selected by the latched mode
    function automatic logic [63:0] apply_op(logic [ModeW-1:0] m, logic [63:0] a,
                                             logic [63:0] b);
        logic a_less;
        a_less = $signed(a) < $signed(b);
        case (m)
            OP_MAX: return a_less ? b : a;
            OP_GCD: return gcd64(magnitude(a), magnitude(b));
            OP_AND: return a & b;
            OP_OR:  return a | b;
            default: return a_less ? a : b;
        endcase
    endfunction

    function automatic void build_levels();
        int unsigned half;
        table_mode = mode_reg;
        for (int unsigned j = 1; j < Levels && (1 << j) <= elem_count; j++) begin
            half = 1 << (j - 1);
            for (int unsigned i = 0; i + half < elem_count; i++)
                level_mem[j][i] = apply_op(table_mode, level_mem[j-1][i],
                                           level_mem[j-1][i+half]);
        end
        is_built = 1'b1;
    endfunction

    function automatic t_answer predict_item(logic qry, logic [63:0] val, logic last,
                                             logic [9:0] left, logic [9:0] right);
        t_answer res;
        int unsigned len, lvl;
        res = '{answer: '0, status: ST_OK};
        if (!qry) begin
            if (is_built) begin
                is_built   = 1'b0;
                elem_count = 0;
            end
            if (elem_count < MaxElements) begin
                level_mem[0][elem_count] = val;
                elem_count++;
            end else begin
                res.status = ST_FULL;
            end
            if (last)
                build_levels();
        end else if (!is_built) begin
            res.status = ST_NOBLD;
        end else if (left > right || right >= elem_count) begin
            res.status = ST_RANGE;
        end else begin
            len = right - left + 1;
            lvl = 0;
            while ((len >> (lvl + 1)) != 0)
                lvl++;
            if (lvl >= Levels)
                lvl = Levels - 1;
            res.answer = apply_op(table_mode, level_mem[lvl][left],
                                  level_mem[lvl][right + 1 - (1 << lvl)]);
        end
        return res;
    endfunction

    // watch the three channels, compare results in order
    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            elem_count = 0;
            is_built   = 1'b0;
            mode_reg   = OP_MIN;
            table_mode = OP_MIN;
            answer_q.delete();
            o_errors  <= 0;
            o_checked <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                mode_reg = i_cfg_data;
            if (i_m_tvalid && i_m_tready) begin
                if (answer_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected: answer %h status %0d",
                             $time, i_m_tdata, i_m_tuser);
                    o_errors <= o_errors + 1;
                end else begin
                    want = answer_q.pop_front();
                    o_checked <= o_checked + 1;
                    if (want.answer !== i_m_tdata || want.status !== i_m_tuser) begin
                        $display("%0t: mismatch: expected answer %h status %0d, got %h %0d",
                                 $time, want.answer, want.status, i_m_tdata, i_m_tuser);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                answer_q.push_back(predict_item(i_s_tuser, i_s_tdata[63:0], i_s_tlast,
                                                i_s_tdata[73:64], i_s_tdata[83:74]));
        end
        o_pending <= answer_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import stq_pkg::*;

    localparam int StallLimit = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;   // load_value[63:0], range_left[73:64], range_right[83:74]
    logic        s_axis_tuser;   // req_type
    logic        s_axis_tlast;   // load_last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // answer
    logic [1:0]  m_axis_tuser;   // status
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_data;

    int          fail_count;
    int          pending;
    int          checked;
    int          items_sent;
    int          idle_cycles;
    bit          no_idle;
    logic [63:0] factor;

    sparse_table_range_query DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    stq_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_s_tlast   (s_axis_tlast),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tuser   (m_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side stalls at random
    always @(posedge i_clk) begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 22);
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > StallLimit) begin
                $display("%0t: no beat for %0d cycles", $time, StallLimit);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_item(logic qry, logic [63:0] val, logic last, logic [9:0] left,
                             logic [9:0] right);
        if (!no_idle && $urandom_range(99) < 22) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= qry;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {4'b0, right, left, val};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic load_value(logic [63:0] val, logic last);
        send_item(1'b0, val, last, 10'($urandom), 10'($urandom));
    endtask

    task automatic query(logic [9:0] left, logic [9:0] right);
        send_item(1'b1, {$urandom, $urandom}, 1'($urandom), left, right);
    endtask

    // hold the sender until every result is back and the block settles
    task automatic drain(int settle);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic set_mode(logic [2:0] m);
        drain(64);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // extremes, zero and multiples of a shared factor so gcd is not trivially one
    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        case ($urandom_range(7))
            0: v = 64'h8000_0000_0000_0000;
            1: v = 64'h7FFF_FFFF_FFFF_FFFF;
            2: v = '0;
            3, 4: begin
                v = factor * $urandom_range(1, 200);
                if ($urandom_range(1)) v = -v;
            end
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic load_array(int n);
        factor = {$urandom_range(3), $urandom} | 64'd1;
        factor = factor << $urandom_range(8);
        for (int k = 0; k < n; k++)
            load_value(pick_value(), k == n - 1);
    endtask

    task automatic query_burst(int cnt, int n);
        int unsigned left, right, kind;
        for (int k = 0; k < cnt; k++) begin
            kind = $urandom_range(99);
            if (kind < 84) begin
                left  = $urandom_range(n - 1);
                right = $urandom_range(n - 1, left);
            end else if (kind < 92) begin
                left  = $urandom_range(1023, 1);
                right = $urandom_range(left - 1);
            end else begin
                left  = $urandom_range(1023);
                right = (n < 1024) ? $urandom_range(1023, n) : $urandom_range(1023);
            end
            query(10'(left), 10'(right));
        end
    endtask

    initial begin
        int n;
        int phase;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = OP_MIN;
        idle_cycles   = 0;
        items_sent    = 0;
        no_idle       = 1'b0;
        factor        = 64'd6;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: query before build, extremes, bad ranges, late mode change
        query(0, 0);
        load_value(64'h8000_0000_0000_0000, 1'b0);
        load_value(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        load_value(64'd0, 1'b0);
        load_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        load_value(64'd1, 1'b1);
        query(0, 4);
        query(0, 0);
        query(4, 4);
        query(1, 3);
        query(3, 1);
        query(0, 5);
        query(1023, 1023);
        set_mode(OP_GCD);
        query(0, 4);
        load_value(64'h8000_0000_0000_0000, 1'b0);
        load_value(64'd12, 1'b0);
        load_value(-64'sd18, 1'b0);
        load_value(64'd0, 1'b1);
        query(0, 3);
        query(1, 2);
        query(3, 3);
        load_value(64'd5, 1'b0);
        query(0, 0);

        // random phases, the first eight walk through every mode code
        phase = 0;
        while (items_sent < 430 || phase < 8) begin
            set_mode(phase < 8 ? phase[2:0] : 3'($urandom_range(7)));
            no_idle = (phase == 3);
            if ($urandom_range(5) == 0) begin
                load_array($urandom_range(1, 6));
                load_value(pick_value(), 1'b0);
                query(10'($urandom), 10'($urandom));
            end
            if (i_cfg_data == OP_GCD)
                n = $urandom_range(1, 24);
            else
                n = ($urandom_range(7) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
            load_array(n);
            query_burst($urandom_range(5, 25), n);
            if ($urandom_range(3) == 0) begin
                set_mode(3'($urandom_range(7)));
                query_burst($urandom_range(3, 10), n);
            end
            phase++;
        end
        no_idle = 1'b0;

        drain(200);
        $display("sent %0d items over %0d random phases, %0d results compared", items_sent,
                 phase, checked);
        $display("covered every mode code, rebuilds, unbuilt and out-of-range queries");
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
